FILE: hw/rtl/arabic_light_stemmer_assert.svh
// Assertion macros used by the stemmer RTL.
`ifndef ARABIC_LIGHT_STEMMER_ASSERT_SVH
`define ARABIC_LIGHT_STEMMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ASL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stemmer assertion failed");

// Next-cycle implication, checked out of reset.
`define ASL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stemmer assertion failed");

`endif

FILE: hw/rtl/asl_pkg.sv
package asl_pkg;

    localparam int LEN_W     = 8;
    localparam int BYTES_W   = 48;
    localparam int MIN_W     = 5;
    localparam int START_W   = 3;
    localparam int AFFIX_W   = 3;
    localparam int N_PREFIX  = 12;
    localparam int N_SUFFIX  = 15;
    localparam int S_DATA_W  = 104;   // word_length + head + tail, already whole bytes
    localparam int M_DATA_W  = 16;    // stem_start + stem_length, padded to two bytes

    localparam logic [MIN_W-1:0] MIN_STEM_RESET = 5'd4;

    typedef struct packed {
        logic               hit;
        logic [AFFIX_W-1:0] len;
    } asl_affix_t;

    typedef logic [BYTES_W-1:0] pat_t;
    typedef logic [AFFIX_W-1:0] alen_t;

    // Prefixes: byte 0 in the low bits. wal fal bal kal lil al w f b k l s
    localparam pat_t PREFIX_PAT [N_PREFIX] = '{
        48'h84D9_A7D8_88D9, 48'h84D9_A7D8_81D9, 48'h84D9_A7D8_A8D8,
        48'h84D9_A7D8_83D9, 48'h0000_84D9_84D9, 48'h0000_84D9_A7D8,
        48'h0000_0000_88D9, 48'h0000_0000_81D9, 48'h0000_0000_A8D8,
        48'h0000_0000_83D9, 48'h0000_0000_84D9, 48'h0000_0000_B3D8
    };
    localparam alen_t PREFIX_LEN [N_PREFIX] = '{
        3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd4,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
    };

    // Suffixes: aligned to the top of the tail window, final byte in bits 47:40.
    // huma kuma kum hum hunna kunna ha na at un in an ta-marbuta ha ya
    localparam pat_t SUFFIX_PAT [N_SUFFIX] = '{
        48'hA7D8_85D9_87D9, 48'hA7D8_85D9_83D9, 48'h85D9_83D9_0000,
        48'h85D9_87D9_0000, 48'h86D9_87D9_0000, 48'h86D9_83D9_0000,
        48'hA7D8_87D9_0000, 48'hA7D8_86D9_0000, 48'hAAD8_A7D8_0000,
        48'h86D9_88D9_0000, 48'h86D9_8AD9_0000, 48'h86D9_A7D8_0000,
        48'hA9D8_0000_0000, 48'h87D9_0000_0000, 48'h8AD9_0000_0000
    };
    localparam alen_t SUFFIX_LEN [N_SUFFIX] = '{
        3'd6, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2
    };

    function automatic pat_t front_mask(input alen_t n);
        front_mask = ~({BYTES_W{1'b1}} << (8 * n));
    endfunction

    function automatic pat_t back_mask(input alen_t n);
        back_mask = ~({BYTES_W{1'b1}} >> (8 * n));
    endfunction

endpackage

FILE: hw/rtl/asl_front.sv
module asl_front (
    input  logic [asl_pkg::LEN_W-1:0]   len,
    input  logic [asl_pkg::MIN_W-1:0]   min_stem,
    input  logic [asl_pkg::BYTES_W-1:0] head,
    output asl_pkg::asl_affix_t         prefix
);
    import asl_pkg::*;

    logic [N_PREFIX-1:0] cand;

    // every candidate in parallel, then the first in list order wins
    always_comb
    begin
        for (int k = 0; k < N_PREFIX; k++)
        begin
            cand[k] = ({1'b0, len} >= (9'(PREFIX_LEN[k]) + 9'(min_stem)))
                      && (((head ^ PREFIX_PAT[k]) & front_mask(PREFIX_LEN[k])) == '0);
        end
    end

    always_comb
    begin
        prefix = '0;
        for (int k = N_PREFIX - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                prefix.hit = 1'b1;
                prefix.len = PREFIX_LEN[k];
            end
        end
    end

endmodule

FILE: hw/rtl/asl_back.sv
module asl_back (
    input  logic [asl_pkg::LEN_W-1:0]   remain,
    input  logic [asl_pkg::MIN_W-1:0]   min_stem,
    input  logic [asl_pkg::BYTES_W-1:0] tail,
    output asl_pkg::asl_affix_t         suffix
);
    import asl_pkg::*;

    logic [N_SUFFIX-1:0] cand;

    always_comb
    begin
        for (int k = 0; k < N_SUFFIX; k++)
        begin
            cand[k] = ({1'b0, remain} >= (9'(SUFFIX_LEN[k]) + 9'(min_stem)))
                      && (((tail ^ SUFFIX_PAT[k]) & back_mask(SUFFIX_LEN[k])) == '0);
        end
    end

    always_comb
    begin
        suffix = '0;
        for (int k = N_SUFFIX - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                suffix.hit = 1'b1;
                suffix.len = SUFFIX_LEN[k];
            end
        end
    end

endmodule

FILE: hw/rtl/arabic_light_stemmer.sv
// A token passes through the input register, then the result register, which drives
// the master side.
// Throughput: one token per cycle; both stages advance whenever the result
// register is empty or being taken, so the slave side only stalls on output back-pressure.
// Reset (rst_n, asynchronous, active low): pipeline empty, min_stem_bytes = 4.
module arabic_light_stemmer #(
    parameter int MAX_WORD_BYTES = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: min_stem_bytes
    input  logic                          cfg_wen,
    input  logic [asl_pkg::MIN_W-1:0]     cfg_wdata,
    // token in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [asl_pkg::S_DATA_W-1:0]  s_tdata,   // word_length[7:0], head_bytes[55:8],
                                                     // tail_bytes[103:56]
    input  logic                          s_tlast,   // last_token
    // stem out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [asl_pkg::M_DATA_W-1:0]  m_tdata,   // stem_start[2:0], stem_length[10:3], zero pad
    output logic                          m_tlast    // last_stem
);
    import asl_pkg::*;

    // lengths above the configured maximum saturate; an 8-bit length never exceeds 255
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((MAX_WORD_BYTES < 255) ? MAX_WORD_BYTES : 255);

    logic [MIN_W-1:0]   min_reg;

    // input register
    logic               in_valid_reg;
    logic [LEN_W-1:0]   len_in_reg;
    logic [BYTES_W-1:0] head_reg;
    logic [BYTES_W-1:0] tail_reg;
    logic               last_in_reg;

    // result register
    logic               out_valid_reg;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   stem_len_reg;
    logic               last_out_reg;

    logic               advance;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   start_ext;
    logic [LEN_W-1:0]   remain;
    logic [LEN_W-1:0]   stem_cut;
    logic               strip_ok;
    asl_affix_t         prefix;
    asl_affix_t         suffix;
    logic [START_W-1:0] start_next;
    logic [LEN_W-1:0]   stem_len_next;

    // result register frees up when empty or when its transfer completes
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_STEM_RESET;
        end
        else if (cfg_wen)
        begin
            min_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            len_in_reg  <= s_tdata[LEN_W-1:0];
            head_reg    <= s_tdata[LEN_W +: BYTES_W];
            tail_reg    <= s_tdata[LEN_W + BYTES_W +: BYTES_W];
            last_in_reg <= s_tlast;
        end
        if (advance && in_valid_reg)
        begin
            start_reg    <= start_next;
            stem_len_reg <= stem_len_next;
            last_out_reg <= last_in_reg;
        end
    end

    assign len = (len_in_reg > LEN_CAP) ? LEN_CAP : len_in_reg;

    asl_front u_front (
        .len      (len),
        .min_stem (min_reg),
        .head     (head_reg),
        .prefix   (prefix)
    );

    // prefix only taken when it leaves at least min bytes, so no underflow here
    assign start_ext = prefix.hit ? LEN_W'(prefix.len) : '0;
    assign remain    = len - start_ext;

    asl_back u_back (
        .remain   (remain),
        .min_stem (min_reg),
        .tail     (tail_reg),
        .suffix   (suffix)
    );

    assign stem_cut = suffix.hit ? LEN_W'(suffix.len) : '0;

    // short token, or nothing left of the stem (only with a zero minimum): pass through
    assign strip_ok = (len > LEN_W'(min_reg)) && (remain > stem_cut);

    always_comb
    begin
        if (strip_ok)
        begin
            start_next    = START_W'(start_ext);
            stem_len_next = remain - stem_cut;
        end
        else
        begin
            start_next    = '0;
            stem_len_next = len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - START_W - LEN_W){1'b0}}, stem_len_reg, start_reg};
    assign m_tlast  = last_out_reg;

`include "arabic_light_stemmer_assert.svh"

    // prefix lengths are even and at most six bytes
    `ASL_ASSERT_IMPL(a_start_legal, clk, rst_n, m_tvalid,
        (m_tdata[0] == 1'b0) && (m_tdata[2:0] != 3'd7))
    // stem never runs past the saturated token end
    `ASL_ASSERT_IMPL(a_stem_fits, clk, rst_n, m_tvalid,
        ({1'b0, stem_len_reg} + 9'(start_reg)) <= 9'(LEN_CAP))
    // slave side stalls only behind a full pipe with a blocked output
    `ASL_ASSERT_IMPL(a_stall_cause, clk, rst_n, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready)
    // a held token moves to the result register on the next edge when it can
    `ASL_ASSERT_NEXT(a_moves_on, clk, rst_n, in_valid_reg && advance, m_tvalid)

endmodule
